>>> src/cmu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmu_pkg
// Shared widths, constants and helpers of the Cayley magnetization update.
// ----------------------------------------------------------------------------
package cmu_pkg;

  localparam int unsigned DW         = 32;
  // denominator stays below 2^50, quotient below 2^38
  localparam int unsigned DEN_W      = 50;
  localparam int unsigned Q_W        = 38;
  localparam int unsigned ACC_W      = DEN_W + Q_W;
  // front stages, divider input stage, divider stages, output register
  localparam int unsigned PIPE_DEPTH = 11 + 1 + Q_W + 1;

  localparam int unsigned NXT1 [3] = '{1, 2, 0};
  localparam int unsigned NXT2 [3] = '{2, 0, 1};

  function automatic logic [3:0] byte_len(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [7:0][3:0] word_byte_lens(input logic [63:0] v);
    logic [7:0][3:0] l;
    for (int j = 0; j < 8; j++) begin
      l[j] = byte_len(v[8*j +: 8]);
    end
    return l;
  endfunction

  function automatic logic [6:0] comb_len(input logic [7:0][3:0] lens);
    logic [6:0] n;
    n = 7'd0;
    for (int j = 0; j < 8; j++) begin
      if (lens[j] != 4'd0) n = 7'(8 * j) + 7'(lens[j]);
    end
    return n;
  endfunction

  // one restoring division step: {remainder, pending dividend bits / quotient bits}
  function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                input logic [DEN_W-1:0] den);
    logic [DEN_W:0] top;
    logic [DEN_W:0] nt;
    logic           qbit;
    top  = acc[ACC_W-1:Q_W-1];
    qbit = (top >= {1'b0, den});
    nt   = qbit ? (top - {1'b0, den}) : top;
    return {nt[DEN_W-1:0], acc[Q_W-2:0], qbit};
  endfunction

endpackage

>>> src/cayley_magnetization_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cayley_magnetization_update_core
// Fully pipelined Cayley-transform rotation of one magnetization vector a beat.
//
//   channel  dir  fields (lsb first)
//   s_axis   in   mag_x mag_y mag_z field_x field_y field_z cell_scale
//   m_axis   out  new_mag_x new_mag_y new_mag_z
//   cfg      in   step_size
//
// One beat accepted every cycle while the output does not stall; the pipeline has
// 11 arithmetic stages, a 38-stage bit-per-stage divider, its input and the output register.
// The divider pipeline sets the latency; throughput is one beat per cycle unless the output stalls.
// Reset clears the valid bits and step_size only.
// The whole pipeline holds while a result waits and m_axis_tready is low.
// ----------------------------------------------------------------------------
module cayley_magnetization_update_core
  import cmu_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // mag_x, mag_y, mag_z, field_x, field_y, field_z, cell_scale
  input  logic [223:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // new_mag_x, new_mag_y, new_mag_z
  output logic [95:0]   m_axis_tdata
);

  logic        en;
  logic [31:0] step_q;
  logic [11:1] vld_q;
  logic [Q_W:0] dvld_q;
  logic        out_valid_q;
  logic [95:0] out_data_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      vld_q       <= '0;
      dvld_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) step_q <= cfg_wdata_i;
      if (en) begin
        {dvld_q, vld_q} <= {dvld_q[Q_W-1:0], vld_q, s_axis_tvalid};
        out_valid_q     <= dvld_q[Q_W];
      end
    end
  end

  // stage 1: products
  logic signed [31:0] in_mag [3];
  logic signed [31:0] in_fld [3];
  logic signed [31:0] mag1_q [3];
  logic [63:0]        tau1_q;
  logic signed [63:0] pa1_q [3];
  logic signed [63:0] pb1_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_mag[k] = $signed(s_axis_tdata[32*k +: 32]);
      in_fld[k] = $signed(s_axis_tdata[96 + 32*k +: 32]);
    end
  end

  // stage 2: cross product, magnitudes
  logic signed [31:0] mag2_q [3];
  logic [63:0]        tau2_q;
  logic [7:0][3:0]    taul2_q;
  logic [62:0]        cm2_q [3];
  logic [2:0]         cneg2_q;

  // stage 3: tau normalized, torque leading bits
  logic signed [31:0] mag3_q [3];
  logic [31:0]        t3_q;
  logic [5:0]         et3_q;
  logic [62:0]        cm3_q [3];
  logic [2:0]         cneg3_q;
  logic [7:0][3:0]    corl3_q;

  // stage 4: torque normalized
  logic signed [31:0] mag4_q [3];
  logic [31:0]        t4_q;
  logic [6:0]         es4_q;
  logic [30:0]        cs4_q [3];
  logic [2:0]         cneg4_q;

  // stage 5: scaled torque
  logic signed [31:0] mag5_q [3];
  logic [62:0]        p5_q [3];
  logic [6:0]         es5_q;
  logic [2:0]         cneg5_q;

  // stage 6: leading bits of scaled torque
  logic signed [31:0] mag6_q [3];
  logic [62:0]        p6_q [3];
  logic [6:0]         es6_q;
  logic [2:0]         cneg6_q;
  logic [7:0][3:0]    pl6_q;

  // stage 7: block exponent
  logic signed [31:0] mag7_q [3];
  logic [62:0]        p7_q [3];
  logic [2:0]         cneg7_q;
  logic signed [9:0]  sh7_q;
  logic [23:0]        u7_q;

  // stage 8: mantissas of a
  logic signed [31:0] mag8_q [3];
  logic signed [24:0] a8_q [3];
  logic [23:0]        am8_q [3];
  logic [23:0]        u8_q;

  // stage 9: squares and a x m products
  logic signed [31:0] mag9_q [3];
  logic signed [24:0] a9_q [3];
  logic [23:0]        u9_q;
  logic [47:0]        sq9_q [3];
  logic [47:0]        usq9_q;
  logic signed [56:0] ap9_q [3];
  logic signed [56:0] an9_q [3];

  // stage 10: denominator and w
  logic signed [31:0] mag10_q [3];
  logic signed [24:0] a10_q [3];
  logic [23:0]        u10_q;
  logic [DEN_W-1:0]   den10_q;
  logic signed [37:0] w10_q [3];

  // stage 11: numerator products
  logic signed [31:0] mag11_q [3];
  logic [DEN_W-1:0]   den11_q;
  logic signed [62:0] uw11_q [3];
  logic signed [62:0] awp11_q [3];
  logic signed [62:0] awn11_q [3];

  // divider lanes
  logic [ACC_W-1:0]   dacc_q [Q_W+1][3];
  logic [DEN_W-1:0]   dden_q [Q_W+1];
  logic signed [31:0] dmag_q [Q_W+1][3];
  logic [2:0]         dneg_q [Q_W+1];

  logic signed [63:0] c2_d [3];
  logic [6:0]         lt3, lc4, l7;
  logic [5:0]         et3_d, ec4_d;
  logic [62:0]        cor3;
  logic signed [9:0]  e7, x7, f7, sh7_d;
  logic [9:0]         nsh8;
  logic [62:0]        shl8 [3];
  logic [23:0]        am8_d [3];
  logic signed [57:0] wd10 [3];
  logic signed [63:0] n12 [3];
  logic [62:0]        nm12 [3];
  logic [Q_W-1:0]     qv [3];
  logic signed [39:0] res [3];
  logic [95:0]        out_data_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c2_d[k] = (pa1_q[k] >>> 1) - (pb1_q[k] >>> 1);
    end

    lt3   = comb_len(taul2_q);
    et3_d = (lt3 > 7'd32) ? 6'(lt3 - 7'd32) : 6'd0;
    cor3  = cm2_q[0] | cm2_q[1] | cm2_q[2];

    lc4   = comb_len(corl3_q);
    ec4_d = (lc4 > 7'd31) ? 6'(lc4 - 7'd31) : 6'd0;

    l7    = comb_len(pl6_q);
    e7    = $signed({3'b000, es6_q}) - 10'sd90;
    x7    = $signed({3'b000, l7}) + e7 - 10'sd1;
    f7    = 10'sd23 - ((x7 > 10'sd0) ? x7 : 10'sd0);
    sh7_d = e7 + f7;

    nsh8 = 10'(-sh7_q);
    for (int k = 0; k < 3; k++) begin
      shl8[k] = p7_q[k] << sh7_q[4:0];
      if (!sh7_q[9]) am8_d[k] = shl8[k][23:0];
      else           am8_d[k] = 24'(p7_q[k] >> nsh8[6:0]);
    end

    for (int k = 0; k < 3; k++) begin
      wd10[k] = 58'(ap9_q[k]) - 58'(an9_q[k]);
    end

    for (int k = 0; k < 3; k++) begin
      n12[k]  = 64'(uw11_q[k]) + 64'(awp11_q[k]) - 64'(awn11_q[k]);
      nm12[k] = (n12[k] < 0) ? 63'(-n12[k]) : 63'(n12[k]);
    end

    for (int k = 0; k < 3; k++) begin
      qv[k] = dacc_q[Q_W][k][Q_W-1:0];
      if (dneg_q[Q_W][k]) res[k] = 40'(dmag_q[Q_W][k]) - $signed({2'b00, qv[k]});
      else                res[k] = 40'(dmag_q[Q_W][k]) + $signed({2'b00, qv[k]});
      if (res[k] > 40'sd2147483647)       out_data_d[32*k +: 32] = 32'h7fff_ffff;
      else if (res[k] < -40'sd2147483648) out_data_d[32*k +: 32] = 32'h8000_0000;
      else                                out_data_d[32*k +: 32] = res[k][31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tau1_q <= 64'(step_q) * 64'(s_axis_tdata[223:192]);
      for (int k = 0; k < 3; k++) begin
        mag1_q[k] <= in_mag[k];
        pa1_q[k]  <= 64'(in_mag[NXT1[k]]) * 64'(in_fld[NXT2[k]]);
        pb1_q[k]  <= 64'(in_mag[NXT2[k]]) * 64'(in_fld[NXT1[k]]);
      end

      tau2_q  <= tau1_q;
      taul2_q <= word_byte_lens(tau1_q);
      for (int k = 0; k < 3; k++) begin
        mag2_q[k]  <= mag1_q[k];
        cneg2_q[k] <= c2_d[k][63];
        cm2_q[k]   <= c2_d[k][63] ? 63'(-c2_d[k]) : 63'(c2_d[k]);
      end

      t3_q    <= 32'(tau2_q >> et3_d);
      et3_q   <= et3_d;
      corl3_q <= word_byte_lens({1'b0, cor3});
      cneg3_q <= cneg2_q;
      for (int k = 0; k < 3; k++) begin
        mag3_q[k] <= mag2_q[k];
        cm3_q[k]  <= cm2_q[k];
      end

      t4_q    <= t3_q;
      es4_q   <= 7'(et3_q) + 7'(ec4_d);
      cneg4_q <= cneg3_q;
      for (int k = 0; k < 3; k++) begin
        mag4_q[k] <= mag3_q[k];
        cs4_q[k]  <= 31'(cm3_q[k] >> ec4_d);
      end

      es5_q   <= es4_q;
      cneg5_q <= cneg4_q;
      for (int k = 0; k < 3; k++) begin
        mag5_q[k] <= mag4_q[k];
        p5_q[k]   <= 63'(t4_q) * 63'(cs4_q[k]);
      end

      es6_q   <= es5_q;
      cneg6_q <= cneg5_q;
      pl6_q   <= word_byte_lens({1'b0, p5_q[0] | p5_q[1] | p5_q[2]});
      for (int k = 0; k < 3; k++) begin
        mag6_q[k] <= mag5_q[k];
        p6_q[k]   <= p5_q[k];
      end

      cneg7_q <= cneg6_q;
      sh7_q   <= sh7_d;
      u7_q    <= (f7 >= 10'sd0) ? (24'd1 << f7[4:0]) : 24'd0;
      for (int k = 0; k < 3; k++) begin
        mag7_q[k] <= mag6_q[k];
        p7_q[k]   <= p6_q[k];
      end

      u8_q <= u7_q;
      for (int k = 0; k < 3; k++) begin
        mag8_q[k] <= mag7_q[k];
        am8_q[k]  <= am8_d[k];
        a8_q[k]   <= cneg7_q[k] ? -$signed({1'b0, am8_d[k]}) : $signed({1'b0, am8_d[k]});
      end

      u9_q   <= u8_q;
      usq9_q <= 48'(u8_q) * 48'(u8_q);
      for (int k = 0; k < 3; k++) begin
        mag9_q[k] <= mag8_q[k];
        a9_q[k]   <= a8_q[k];
        sq9_q[k]  <= 48'(am8_q[k]) * 48'(am8_q[k]);
        ap9_q[k]  <= 57'(a8_q[NXT1[k]]) * 57'(mag8_q[NXT2[k]]);
        an9_q[k]  <= 57'(a8_q[NXT2[k]]) * 57'(mag8_q[NXT1[k]]);
      end

      u10_q   <= u9_q;
      den10_q <= DEN_W'(usq9_q) + DEN_W'(sq9_q[0]) + DEN_W'(sq9_q[1]) + DEN_W'(sq9_q[2]);
      for (int k = 0; k < 3; k++) begin
        mag10_q[k] <= mag9_q[k];
        a10_q[k]   <= a9_q[k];
        w10_q[k]   <= 38'(wd10[k] >>> 20);
      end

      den11_q <= den10_q;
      for (int k = 0; k < 3; k++) begin
        mag11_q[k] <= mag10_q[k];
        uw11_q[k]  <= 63'($signed({1'b0, u10_q})) * 63'(w10_q[k]);
        awp11_q[k] <= 63'(a10_q[NXT1[k]]) * 63'(w10_q[NXT2[k]]);
        awn11_q[k] <= 63'(a10_q[NXT2[k]]) * 63'(w10_q[NXT1[k]]);
      end

      // divider input: dividend is |n| * 2^21
      dden_q[0] <= den11_q;
      for (int k = 0; k < 3; k++) begin
        dmag_q[0][k] <= mag11_q[k];
        dneg_q[0][k] <= n12[k][63];
        dacc_q[0][k] <= ACC_W'(nm12[k]) << 21;
      end

      for (int i = 0; i < Q_W; i++) begin
        dden_q[i+1] <= dden_q[i];
        dneg_q[i+1] <= dneg_q[i];
        for (int k = 0; k < 3; k++) begin
          dmag_q[i+1][k] <= dmag_q[i][k];
          dacc_q[i+1][k] <= div_step(dacc_q[i][k], dden_q[i]);
        end
      end

      out_data_q <= out_data_d;
    end
  end

endmodule

>>> src/cmu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmu_checker
// Port-level checks of the Cayley magnetization update core.
// ----------------------------------------------------------------------------
module cmu_checker
  import cmu_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  input logic          s_axis_tvalid,
  input logic          s_axis_tready,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [95:0]   m_axis_tdata
);

  logic [6:0] inflight_q;
  logic       s_beat, m_beat;

  assign s_beat = s_axis_tvalid && s_axis_tready;
  assign m_beat = m_axis_tvalid && m_axis_tready;

  // beats taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 7'(s_beat) - 7'(m_beat);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != 7'd0)
    else $error("result beat without a matching input beat");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 7'(PIPE_DEPTH))
    else $error("more beats in flight than pipeline stages");

endmodule

bind cayley_magnetization_update_core cmu_checker u_cmu_checker (.*);

>>> verif/tb_cayley_magnetization_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cayley_magnetization_update_core
// Self-checking bench for the Cayley magnetization update pipeline.
// A short stimulus table covers field extremes, zero step, zero torque, huge
// rotation and saturation; random cells follow under several step sizes.
// Every output beat is compared with a bit-exact model of the rotation or a tabled result.
// Both stream sides get random idle bursts except near the end of the run.
// ----------------------------------------------------------------------------
module tb_cayley_magnetization_update_core
  import cmu_pkg::*;
;

  localparam int unsigned LAT       = PIPE_DEPTH;
  localparam int          N_RANDOM  = 530;
  localparam int          QUIET_AT  = 480;
  localparam int          CYC_LIMIT = 400000;

  typedef struct {
    logic [31:0] step;
    logic [31:0] mx, my, mz, hx, hy, hz, scale;
    bit          typed;
    logic [31:0] ex, ey, ez;
  } row_t;

  typedef struct packed {
    logic [31:0] z, y, x;
  } vec_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;

  logic [31:0]  step_q = '0;
  vec_t         mag_expected[$];
  int           errors = 0;
  int           sent = 0;
  bit           quiet = 1'b0;
  int           cycles = 0;
  row_t         rows[$];

  cayley_magnetization_update_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  function automatic int bit_len(input longint unsigned v);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = i + 1;
    end
    return n;
  endfunction

  // bit-exact rotation of one cell
  function automatic vec_t rotate_cell(input row_t c, input logic [31:0] h);
    longint          m[3], fh[3], cc[3], a[3], w[3];
    longint unsigned cm[3], pm[3], cmax, pmax, tau, t, den, am, nm, q, r;
    bit              cn[3];
    int              k1, k2, et, ec, e, l, f, sh;
    longint          u, n, res;
    logic [31:0]     o[3];
    m[0] = longint'($signed(c.mx)); m[1] = longint'($signed(c.my));
    m[2] = longint'($signed(c.mz));
    fh[0] = longint'($signed(c.hx)); fh[1] = longint'($signed(c.hy));
    fh[2] = longint'($signed(c.hz));
    tau = 64'(h) * 64'(c.scale);
    et = 0; ec = 0; cmax = 0; pmax = 0;
    t = tau;
    if (bit_len(tau) > 32) begin
      et = bit_len(tau) - 32;
      t = tau >> et;
    end
    for (int k = 0; k < 3; k++) begin
      k1 = (k + 1) % 3; k2 = (k + 2) % 3;
      cc[k] = ((m[k1] * fh[k2]) >>> 1) - ((m[k2] * fh[k1]) >>> 1);
      cn[k] = cc[k] < 0;
      cm[k] = cn[k] ? -cc[k] : cc[k];
      if (cm[k] > cmax) cmax = cm[k];
    end
    if (bit_len(cmax) > 31) ec = bit_len(cmax) - 31;
    for (int k = 0; k < 3; k++) begin
      pm[k] = t * (cm[k] >> ec);
      if (pm[k] > pmax) pmax = pm[k];
    end
    e = et + ec - 90;
    l = bit_len(pmax);
    f = 23 - ((l + e - 1) > 0 ? (l + e - 1) : 0);
    sh = e + f;
    u = (f >= 0) ? (longint'(1) << f) : 0;
    den = u * u;
    for (int k = 0; k < 3; k++) begin
      if (sh >= 0) am = (sh < 64) ? (pm[k] << sh) : 0;
      else am = (-sh < 64) ? (pm[k] >> (-sh)) : 0;
      a[k] = cn[k] ? -longint'(am) : longint'(am);
      den += am * am;
    end
    for (int k = 0; k < 3; k++) begin
      k1 = (k + 1) % 3; k2 = (k + 2) % 3;
      w[k] = (a[k1] * m[k2] - a[k2] * m[k1]) >>> 20;
    end
    for (int k = 0; k < 3; k++) begin
      k1 = (k + 1) % 3; k2 = (k + 2) % 3;
      n = u * w[k] + (a[k1] * w[k2] - a[k2] * w[k1]);
      nm = (n < 0) ? -n : n;
      q = nm / den;
      r = nm % den;
      q = (q << 10) + (r << 10) / den;
      r = (r << 10) % den;
      q = (q << 11) + (r << 11) / den;
      res = m[k] + ((n < 0) ? -longint'(q) : longint'(q));
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      o[k] = res[31:0];
    end
    return '{z: o[2], y: o[1], x: o[0]};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic write_step(input logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    step_q   = v;
  endtask

  // stop offering beats, then let the pipeline empty
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (mag_expected.size() == 0);
    repeat (LAT + 8) @(negedge clk_i);
  endtask

  task automatic send_cell(input row_t c);
    int gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {c.scale, c.hz, c.hy, c.hx, c.mz, c.my, c.mx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (c.typed) mag_expected.push_back('{z: c.ez, y: c.ey, x: c.ex});
    else mag_expected.push_back(rotate_cell(c, step_q));
    sent++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t rand_cell();
    row_t c;
    c.typed = 1'b0;
    c.step = '0; c.ex = '0; c.ey = '0; c.ez = '0;
    if ($urandom_range(0, 3) != 0) begin
      // magnetization of roughly unit length, field of varied size
      c.mx = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
      c.my = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
      c.mz = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
      c.hx = $urandom >>> $urandom_range(0, 24);
      c.hy = $urandom >>> $urandom_range(0, 24);
      c.hz = $urandom >>> $urandom_range(0, 24);
      c.scale = $urandom >> $urandom_range(0, 20);
    end else begin
      c.mx = rand_word(); c.my = rand_word(); c.mz = rand_word();
      c.hx = rand_word(); c.hy = rand_word(); c.hz = rand_word();
      c.scale = rand_word();
    end
    return c;
  endfunction

  // receiver stalls in random bursts
  int ready_hold = 0;
  always @(negedge clk_i) begin
    if (quiet || !rst_ni) begin
      m_axis_tready <= rst_ni;
    end else if (ready_hold > 0) begin
      ready_hold    <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      ready_hold    <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    vec_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (mag_expected.size() == 0) begin
        report_mismatch("unexpected beat", got.x, 32'h0);
      end else begin
        want = mag_expected.pop_front();
        if (got.x !== want.x) report_mismatch("new_mag_x", got.x, want.x);
        if (got.y !== want.y) report_mismatch("new_mag_y", got.y, want.y);
        if (got.z !== want.z) report_mismatch("new_mag_z", got.z, want.z);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout with %0d beats outstanding", mag_expected.size());
      $display("cayley_magnetization_update_core verification failed");
      $finish;
    end
  end

  initial begin
    row_t c;
    logic [31:0] steps[6];
    // step 0 after reset: magnetization passes through
    rows.push_back('{0, 32'h7fff_ffff, 32'h8000_0000, 32'h4000_0000, 32'h7fff_ffff,
                     32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1,
                     32'h7fff_ffff, 32'h8000_0000, 32'h4000_0000});
    rows.push_back('{0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 1,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    rows.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0});
    // full step, zero scale and zero field: no rotation
    rows.push_back('{32'hffff_ffff, 32'h1234_5678, 32'hc000_0000, 32'h0000_0001,
                     32'h7fff_ffff, 32'h0100_0000, 32'h8000_0000, 0, 1,
                     32'h1234_5678, 32'hc000_0000, 32'h0000_0001});
    rows.push_back('{32'hffff_ffff, 32'h4000_0000, 32'h4000_0000, 32'hc000_0000,
                     0, 0, 0, 32'hffff_ffff, 1,
                     32'h4000_0000, 32'h4000_0000, 32'hc000_0000});
    // huge rotation
    rows.push_back('{32'hffff_ffff, 32'h4000_0000, 0, 0, 0, 32'h7fff_ffff, 0,
                     32'hffff_ffff, 0, 0, 0, 0});
    rows.push_back('{32'hffff_ffff, 32'h2d41_3ccc, 32'hd2be_c334, 32'h1000_0000,
                     32'h8000_0000, 32'h0000_1000, 32'h7fff_ffff,
                     32'h0001_0000, 0, 0, 0, 0});
    // saturating outputs
    rows.push_back('{32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                     32'h0010_0000, 32'hfff0_0000, 32'h0001_0000,
                     32'h0002_0000, 0, 0, 0, 0});
    rows.push_back('{32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                     32'hffff_ffff, 0, 0, 0, 0});
    // small and half steps, tiny rotations
    rows.push_back('{32'h0000_0001, 32'h4000_0000, 0, 0, 0, 32'h0000_1000, 0,
                     32'h0001_0000, 0, 0, 0, 0});
    rows.push_back('{32'h0100_0000, 32'h4000_0000, 0, 0, 0, 32'h0000_1000, 0,
                     32'h0001_0000, 0, 0, 0, 0});
    rows.push_back('{32'h0100_0000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000,
                     32'hffff_f000, 32'h0000_3000, 32'h0000_0001,
                     32'h0004_0000, 0, 0, 0, 0});
    rows.push_back('{32'h8000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001,
                     32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff,
                     32'h0000_0001, 0, 0, 0, 0});
    rows.push_back('{32'h8000_0000, 32'hc000_0000, 32'h3000_0000, 32'h0800_0000,
                     32'h0012_3456, 32'hfedc_ba98, 32'h0000_7fff,
                     32'h0000_8000, 0, 0, 0, 0});

    steps = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h0010_0000,
              32'h0400_0000, 32'h4000_0000};

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].step !== step_q) begin
        drain();
        write_step(rows[i].step);
      end
      send_cell(rows[i]);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 90 == 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        drain();
        write_step(($urandom_range(0, 2) == 0) ? $urandom : steps[(i / 90) % 6]);
      end
      if (i == QUIET_AT) quiet = 1'b1;
      c = rand_cell();
      send_cell(c);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    wait (mag_expected.size() == 0);
    repeat (LAT + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("cayley_magnetization_update_core verification clean");
    end else begin
      $display("cayley_magnetization_update_core verification failed");
    end
    $finish;
  end

endmodule
